// ===== sv/slcfr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// slcfr_pkg
// shared types and constants of the sync/length/checksum frame receiver
// ----------------------------------------------------------------------------
package slcfr_pkg;

    // receive buffer size, bounds the longest body that can be taken
    localparam int BUFFER_BYTES = 1024;

    localparam int LEN_W   = 16;  // width of the length field on the wire
    localparam int BODY_W  = 10;  // body length and body counter
    localparam int SUM_W   = 16;  // running checksum
    localparam int MISS_W  = 8;   // heartbeat miss counter
    localparam int CFG_W   = 16;  // widest configuration register
    localparam int CFG_IDX = 2;   // configuration index bits

    localparam logic [7:0]        SYNC_1   = 8'h55;
    localparam logic [7:0]        SYNC_2   = 8'hAA;
    localparam logic [SUM_W-1:0]  SYNC_SUM = SUM_W'(8'h55 + 8'hAA);
    localparam logic [LEN_W-1:0]  MIN_BODY = LEN_W'(4);
    localparam logic [LEN_W-1:0]  BUF_LIMIT = LEN_W'(BUFFER_BYTES - 4);
    localparam logic [BODY_W-1:0] HDR_TRL  = BODY_W'(4);
    localparam logic [MISS_W-1:0] MISS_MAX = {MISS_W{1'b1}};

    // reset values of the configuration registers
    localparam logic [BODY_W-1:0] RST_MAX_BODY   = BODY_W'(1020);
    localparam logic [15:0]       RST_HB_ID      = 16'h0000;
    localparam logic [MISS_W-1:0] RST_MISS_LIMIT = MISS_W'(10);
    localparam logic              RST_CK_HIGH    = 1'b1;

    typedef enum logic [CFG_IDX-1:0] {
        REG_MAX_BODY   = 2'd0,
        REG_HB_ID      = 2'd1,
        REG_MISS_LIMIT = 2'd2,
        REG_CK_HIGH    = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        PH_HUNT1  = 3'd0,
        PH_HUNT2  = 3'd1,
        PH_LEN_LO = 3'd2,
        PH_LEN_HI = 3'd3,
        PH_BODY   = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        KIND_PAYLOAD  = 3'd0,
        KIND_ACCEPTED = 3'd1,
        KIND_CK_FAIL  = 3'd2,
        KIND_LEN_REJ  = 3'd3,
        KIND_LINK     = 3'd4
    } t_kind;

    // what the parser makes of one received byte
    typedef struct packed {
        logic              valid;   // byte yields a result
        t_kind             kind;
        logic [7:0]        data;
        logic [15:0]       id;
        logic [BODY_W-1:0] plen;
        logic              hb_hit;  // accepted frame carried the heartbeat id
    } t_parse_res;

endpackage : slcfr_pkg
`default_nettype wire

// ===== sv/slcfr_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// slcfr_parser
// frame state machine: sync hunt, length check, body and checksum
// ----------------------------------------------------------------------------
module slcfr_parser
    import slcfr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,         // commit one received byte
    input  wire logic [7:0]        i_byte,
    input  wire logic [BODY_W-1:0] i_max_body,
    input  wire logic [15:0]       i_hb_id,
    input  wire logic              i_ck_high,
    output t_parse_res             o_res
);

    t_phase            r_phase, n_phase;
    logic [7:0]        r_len_low, n_len_low;
    logic [BODY_W-1:0] r_body_len, n_body_len;
    logic [BODY_W-1:0] r_count, n_count;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [7:0]        r_first, n_first;
    logic [15:0]       r_id, n_id;

    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  limit;
    logic [SUM_W-1:0]  sum_add;
    logic [BODY_W:0]   idx_p2;
    logic [SUM_W-1:0]  rx_sum;
    logic [BODY_W-1:0] plen;

    assign len     = {i_byte, r_len_low};
    assign limit   = ({{(LEN_W-BODY_W){1'b0}}, i_max_body} > BUF_LIMIT) ? BUF_LIMIT
                   : {{(LEN_W-BODY_W){1'b0}}, i_max_body};
    assign sum_add = r_sum + {{(SUM_W-8){1'b0}}, i_byte};
    assign idx_p2  = {1'b0, r_count} + (BODY_W+1)'(2);
    assign rx_sum  = i_ck_high ? {r_first, i_byte} : {i_byte, r_first};
    assign plen    = r_body_len - HDR_TRL;

    always_comb begin
        n_phase    = r_phase;
        n_len_low  = r_len_low;
        n_body_len = r_body_len;
        n_count    = r_count;
        n_sum      = r_sum;
        n_first    = r_first;
        n_id       = r_id;
        o_res      = '{valid: 1'b0, kind: KIND_PAYLOAD, data: 8'h00, id: 16'h0000,
                       plen: '0, hb_hit: 1'b0};
        case (r_phase)
            PH_HUNT1: begin
                if (i_byte == SYNC_1) begin
                    n_phase = PH_HUNT2;
                end
            end
            PH_HUNT2: begin
                if (i_byte == SYNC_2) begin
                    n_phase = PH_LEN_LO;
                    n_sum   = SYNC_SUM;
                end else if (i_byte != SYNC_1) begin
                    n_phase = PH_HUNT1;
                end
            end
            PH_LEN_LO: begin
                n_len_low = i_byte;
                n_sum     = sum_add;
                n_phase   = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                if (len < MIN_BODY || len > limit) begin
                    n_phase     = PH_HUNT1;
                    o_res.valid = 1'b1;
                    o_res.kind  = KIND_LEN_REJ;
                end else begin
                    n_body_len = len[BODY_W-1:0];
                    n_count    = '0;
                    n_sum      = sum_add;
                    n_phase    = PH_BODY;
                end
            end
            PH_BODY: begin
                n_count = r_count + BODY_W'(1);
                if (idx_p2 < {1'b0, r_body_len}) begin
                    n_sum = sum_add;
                    if (r_count == '0) begin
                        n_id = {8'h00, i_byte};
                    end else if (r_count == BODY_W'(1)) begin
                        n_id = {i_byte, r_id[7:0]};
                    end else begin
                        o_res.valid = 1'b1;
                        o_res.kind  = KIND_PAYLOAD;
                        o_res.data  = i_byte;
                        o_res.id    = r_id;
                        o_res.plen  = plen;
                    end
                end else if (idx_p2 == {1'b0, r_body_len}) begin
                    n_first = i_byte;
                end else begin
                    // last checksum byte closes the frame
                    n_phase     = PH_HUNT1;
                    o_res.valid = 1'b1;
                    o_res.id    = r_id;
                    o_res.plen  = plen;
                    if (rx_sum == r_sum) begin
                        o_res.kind   = KIND_ACCEPTED;
                        o_res.hb_hit = (r_id == i_hb_id);
                    end else begin
                        o_res.kind = KIND_CK_FAIL;
                    end
                end
            end
            default: begin
                n_phase = PH_HUNT1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT1;
        end else if (i_en) begin
            r_phase <= n_phase;
        end
    end

    // frame fields are always written before they are read
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_len_low  <= n_len_low;
            r_body_len <= n_body_len;
            r_count    <= n_count;
            r_sum      <= n_sum;
            r_first    <= n_first;
            r_id       <= n_id;
        end
    end

endmodule : slcfr_parser
`default_nettype wire

// ===== sv/slcfr_link_mon.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// slcfr_link_mon
// heartbeat supervision: saturating miss counter and link flag
// ----------------------------------------------------------------------------
module slcfr_link_mon
    import slcfr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_tick,     // committed heartbeat tick
    input  wire logic              i_hb_hit,   // committed heartbeat frame
    input  wire logic [MISS_W-1:0] i_miss_limit,
    output logic                   o_link_next // link state after this item
);

    logic [MISS_W-1:0] r_miss, n_miss;
    logic              r_link, n_link;
    logic [MISS_W-1:0] miss_inc;

    assign miss_inc = (r_miss == MISS_MAX) ? r_miss : r_miss + MISS_W'(1);

    always_comb begin
        n_miss = r_miss;
        n_link = r_link;
        if (i_tick) begin
            n_miss = miss_inc;
            if (miss_inc > i_miss_limit) begin
                n_link = 1'b0;
            end
        end else if (i_hb_hit) begin
            n_miss = '0;
            n_link = 1'b1;
        end
    end

    assign o_link_next = n_link;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_miss <= '0;
            r_link <= 1'b0;
        end else begin
            r_miss <= n_miss;
            r_link <= n_link;
        end
    end

endmodule : slcfr_link_mon
`default_nettype wire

// ===== sv/sync_length_checksum_frame_receiver.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sync_length_checksum_frame_receiver
// frame receiver for 0x55 0xAA framed packets with heartbeat link monitor
// ----------------------------------------------------------------------------
//  channel  direction  handshake               payload
//  in       input      i_in_valid / o_in_stall  i_in_action, i_in_rx_byte
//  out      output     o_out_valid / i_out_stall o_out_kind .. o_out_link_active
//  cfg      input      i_cfg_we                 i_cfg_index, i_cfg_data
//
//  one transaction per cycle sustained while the result side does not stall; a
//  result passes through the input register, then the result register
//  the frame state update is one byte-wide step, so nothing iterates
//  synchronous active-low reset clears control state and loads register
//  defaults; no clearing pass
//  a stalled result holds; the input register keeps moving while the item
//  there gives no result, otherwise it waits for the result register
// ----------------------------------------------------------------------------
module sync_length_checksum_frame_receiver
    import slcfr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input transactions
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_in_action,
    input  wire logic [7:0]         i_in_rx_byte,
    // result transactions
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [2:0]              o_out_kind,
    output logic [7:0]              o_out_payload_byte,
    output logic [15:0]             o_out_packet_id,
    output logic [BODY_W-1:0]       o_out_payload_length,
    output logic                    o_out_link_active,
    // configuration writes
    input  wire logic               i_cfg_we,
    input  wire logic [CFG_IDX-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]   i_cfg_data
);

    // configuration registers
    logic [BODY_W-1:0] r_max_body;
    logic [15:0]       r_hb_id;
    logic [MISS_W-1:0] r_miss_limit;
    logic              r_ck_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_body   <= RST_MAX_BODY;
            r_hb_id      <= RST_HB_ID;
            r_miss_limit <= RST_MISS_LIMIT;
            r_ck_high    <= RST_CK_HIGH;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_MAX_BODY:   r_max_body   <= i_cfg_data[BODY_W-1:0];
                REG_HB_ID:      r_hb_id      <= i_cfg_data[15:0];
                REG_MISS_LIMIT: r_miss_limit <= i_cfg_data[MISS_W-1:0];
                REG_CK_HIGH:    r_ck_high    <= i_cfg_data[0];
                default:        r_ck_high    <= r_ck_high;
            endcase
        end
    end

    // input register
    logic       r_in_valid;
    logic       r_in_action;
    logic [7:0] r_in_byte;

    // result register
    logic              r_out_valid;
    t_kind             r_out_kind;
    logic [7:0]        r_out_byte;
    logic [15:0]       r_out_id;
    logic [BODY_W-1:0] r_out_plen;
    logic              r_out_link;

    t_parse_res parse_res;
    logic       link_next;
    logic       has_result;   // item in the input register yields a result
    logic       out_free;     // result register can take a new result
    logic       advance;      // item in the input register is committed
    logic       in_take;

    assign has_result = r_in_action | parse_res.valid;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && (out_free || !has_result);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_action <= i_in_action;
            r_in_byte   <= i_in_rx_byte;
        end
    end

    // byte path: framing, length and checksum
    slcfr_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (advance && !r_in_action),
        .i_byte     (r_in_byte),
        .i_max_body (r_max_body),
        .i_hb_id    (r_hb_id),
        .i_ck_high  (r_ck_high),
        .o_res      (parse_res)
    );

    // tick path and heartbeat frames drive the link flag
    slcfr_link_mon u_link_mon (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (advance && r_in_action),
        .i_hb_hit     (advance && !r_in_action && parse_res.hb_hit),
        .i_miss_limit (r_miss_limit),
        .o_link_next  (link_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && has_result) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // a tick reports kind link and link status only, all other fields zero
    always_ff @(posedge i_clk) begin
        if (advance && has_result) begin
            r_out_link <= link_next;
            if (r_in_action) begin
                r_out_kind <= KIND_LINK;
                r_out_byte <= 8'h00;
                r_out_id   <= 16'h0000;
                r_out_plen <= '0;
            end else begin
                r_out_kind <= parse_res.kind;
                r_out_byte <= parse_res.data;
                r_out_id   <= parse_res.id;
                r_out_plen <= parse_res.plen;
            end
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_out_kind           = r_out_kind;
    assign o_out_payload_byte   = r_out_byte;
    assign o_out_packet_id      = r_out_id;
    assign o_out_payload_length = r_out_plen;
    assign o_out_link_active    = r_out_link;

endmodule : sync_length_checksum_frame_receiver
`default_nettype wire
